@@ src/lprsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprsc_pkg
// Types, codes and byte-class helpers for the LPR session classifier.
// ----------------------------------------------------------------------------
package lprsc_pkg;

  // byte index within a packet, saturating
  localparam int unsigned POSITION_BITS = 16;

  localparam logic [7:0] LINE_FEED       = 8'h0A;
  localparam logic [7:0] THRESHOLD_RESET = 8'd5;

  // configuration port
  localparam int unsigned PADDR_W = 3;
  localparam logic        REG_THRESHOLD = 1'b0;

  // session phases
  localparam logic [2:0] PH_COMMAND    = 3'd0;
  localparam logic [2:0] PH_RECEIVE    = 3'd1;
  localparam logic [2:0] PH_REPLY_FILE = 3'd2;
  localparam logic [2:0] PH_REPLY      = 3'd3;
  localparam logic [2:0] PH_IGNORE     = 3'd4;

  // top-level command bytes
  localparam logic [7:0] CMD_PRINT      = 8'd1;
  localparam logic [7:0] CMD_RECEIVE    = 8'd2;
  localparam logic [7:0] CMD_SEND_SHORT = 8'd3;
  localparam logic [7:0] CMD_SEND_LONG  = 8'd4;
  localparam logic [7:0] CMD_REMOVE     = 8'd5;

  // receive-job subcommands
  localparam logic [7:0] SUB_ABORT   = 8'd1;
  localparam logic [7:0] SUB_CONTROL = 8'd2;
  localparam logic [7:0] SUB_DATA    = 8'd3;

  typedef enum logic [1:0] {
    VERDICT_IN_PROCESS   = 2'd0,
    VERDICT_IDENTIFIED   = 2'd1,
    VERDICT_NO_MATCH     = 2'd2,
    VERDICT_INCOMPATIBLE = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       from_responder;
    logic       first_of_packet;
    logic       last_of_packet;
    logic       new_flow;
  } lprsc_item_t;

  function automatic logic is_graphic(logic [7:0] b);
    return (b >= 8'h21) && (b <= 8'h7E);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_blank(logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

endpackage

@@ src/lprsc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprsc_item_if / lprsc_result_if
// Valid/ready channels for payload bytes in and verdicts out.
// ----------------------------------------------------------------------------
interface lprsc_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       from_responder;
  logic       first_of_packet;
  logic       last_of_packet;
  logic       new_flow;

  modport source (
    output valid, payload_byte, from_responder, first_of_packet, last_of_packet,
           new_flow,
    input  ready
  );
  modport sink (
    input  valid, payload_byte, from_responder, first_of_packet, last_of_packet,
           new_flow,
    output ready
  );
endinterface

interface lprsc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface

@@ src/lprsc_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprsc_engine
// Session and per-packet scanner state; one byte per step, verdict on last.
// ----------------------------------------------------------------------------
module lprsc_engine
  import lprsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  lprsc_item_t item_i,
  input  logic [7:0]  threshold_i,
  output logic        res_valid_o,
  output verdict_e    verdict_o
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic [2:0]               phase_q, phase_d;
  logic [7:0]               count_q, count_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [7:0]               lead_q, lead_d;
  logic                     stage_q, stage_d;
  logic                     bad_q, bad_d;
  logic                     dir_q, dir_d;

  // values after flow/packet restart
  logic [2:0]               phase_e;
  logic [7:0]               count_e;
  logic [POSITION_BITS-1:0] pos_e;
  logic [7:0]               lead_e;
  logic                     stage_e, bad_e, dir_e, restart;

  logic [7:0] lead_n, b;
  logic       stage_n, bad_n, dir_n, last;
  logic       pos_zero, pos_one, pos_lt2, pos_lt4;
  logic [8:0] n;
  logic [2:0] phase_j;
  logic [7:0] count_j;
  verdict_e   verdict;

  assign b    = item_i.payload_byte;
  assign last = item_i.last_of_packet;

  always_comb begin
    restart = item_i.new_flow | item_i.first_of_packet;
    phase_e = item_i.new_flow ? PH_COMMAND : phase_q;
    count_e = item_i.new_flow ? 8'd0 : count_q;
    pos_e   = restart ? '0 : pos_q;
    lead_e  = restart ? 8'd0 : lead_q;
    stage_e = restart ? 1'b0 : stage_q;
    bad_e   = restart ? 1'b0 : bad_q;
    dir_e   = restart ? 1'b0 : dir_q;

    pos_zero = (pos_e == '0);
    pos_one  = (pos_e == POSITION_BITS'(1));
    pos_lt2  = (pos_e < POSITION_BITS'(2));
    pos_lt4  = (pos_e < POSITION_BITS'(4));

    lead_n  = lead_e;
    dir_n   = dir_e;
    bad_n   = bad_e;
    stage_n = stage_e;

    if (pos_zero) begin
      lead_n = b;
      dir_n  = item_i.from_responder;
    end else if (phase_e == PH_COMMAND && lead_e == CMD_RECEIVE) begin
      if (last ? (b != LINE_FEED) : !is_graphic(b)) bad_n = 1'b1;
    end else if (phase_e == PH_RECEIVE && lead_e == SUB_ABORT) begin
      if (!pos_lt2 || b != LINE_FEED) bad_n = 1'b1;
    end else if (phase_e == PH_RECEIVE && (lead_e == SUB_CONTROL || lead_e == SUB_DATA)) begin
      if (pos_one) begin
        if (!is_digit(b)) bad_n = 1'b1;
      end else if (!stage_e) begin
        // count field: digits up to one blank
        if (last || b == LINE_FEED) bad_n = 1'b1;
        else if (is_blank(b)) stage_n = 1'b1;
        else if (!is_digit(b)) bad_n = 1'b1;
      end else begin
        if (last ? (b != LINE_FEED) : !is_graphic(b)) bad_n = 1'b1;
      end
    end
  end

  // verdict and session update on the last byte
  always_comb begin
    n       = {1'b0, count_e} + 9'd1;
    phase_j = phase_e;
    count_j = count_e;
    verdict = VERDICT_INCOMPATIBLE;
    unique case (phase_e) inside
      PH_COMMAND: begin
        if (dir_n || pos_lt2) begin
          verdict = VERDICT_INCOMPATIBLE;
        end else if (lead_n == CMD_RECEIVE) begin
          if (!bad_n) begin
            phase_j = PH_REPLY;
            verdict = VERDICT_IN_PROCESS;
          end
        end else if (lead_n == CMD_PRINT || lead_n == CMD_SEND_SHORT ||
                     lead_n == CMD_SEND_LONG || lead_n == CMD_REMOVE) begin
          phase_j = PH_IGNORE;
          verdict = VERDICT_IN_PROCESS;
        end
      end
      PH_RECEIVE: begin
        if (dir_n) begin
          verdict = VERDICT_IN_PROCESS;
        end else if (pos_zero) begin
          verdict = VERDICT_INCOMPATIBLE;
        end else if (lead_n == SUB_ABORT) begin
          if (!bad_n) begin
            phase_j = PH_REPLY;
            verdict = VERDICT_IN_PROCESS;
          end
        end else if (lead_n == SUB_CONTROL || lead_n == SUB_DATA) begin
          if (!pos_lt4 && !bad_n) begin
            phase_j = PH_REPLY_FILE;
            verdict = VERDICT_IN_PROCESS;
          end
        end
      end
      PH_REPLY_FILE, PH_REPLY: begin
        if (!dir_n) begin
          verdict = VERDICT_IN_PROCESS;
        end else if (!pos_zero) begin
          verdict = VERDICT_NO_MATCH;
        end else begin
          count_j = (n > {1'b0, threshold_i}) ? threshold_i : n[7:0];
          if (n >= {1'b0, threshold_i}) begin
            phase_j = PH_IGNORE;
            verdict = VERDICT_IDENTIFIED;
          end else begin
            phase_j = (phase_e == PH_REPLY_FILE) ? PH_REPLY : PH_RECEIVE;
            verdict = VERDICT_IN_PROCESS;
          end
        end
      end
      PH_IGNORE: verdict = VERDICT_IN_PROCESS;
      default:   verdict = VERDICT_INCOMPATIBLE;
    endcase
  end

  always_comb begin
    if (last) begin
      phase_d = phase_j;
      count_d = count_j;
      pos_d   = '0;
      lead_d  = 8'd0;
      stage_d = 1'b0;
      bad_d   = 1'b0;
      dir_d   = 1'b0;
    end else begin
      phase_d = phase_e;
      count_d = count_e;
      pos_d   = (pos_e == POS_MAX) ? pos_e : pos_e + POSITION_BITS'(1);
      lead_d  = lead_n;
      stage_d = stage_n;
      bad_d   = bad_n;
      dir_d   = dir_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_COMMAND;
      count_q <= 8'd0;
      pos_q   <= '0;
      lead_q  <= 8'd0;
      stage_q <= 1'b0;
      bad_q   <= 1'b0;
      dir_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      lead_q  <= lead_d;
      stage_q <= stage_d;
      bad_q   <= bad_d;
      dir_q   <= dir_d;
    end
  end

  assign res_valid_o = step_i & last;
  assign verdict_o   = verdict;

endmodule

@@ src/lpr_session_classifier_top.sv @@
`timescale 1ns / 1ps
// A last byte passes the input register and then the verdict register before its verdict shows on result_o.
// One payload byte per cycle while no last byte waits on an untaken verdict; the scanner takes a byte per step.
// An input register and an output register part the two channels, so bytes keep
// flowing while a verdict waits; only a second last byte stalls behind it.
// Reset (rst_ni, async, low) returns to command phase, count zero, threshold 5.
// ----------------------------------------------------------------------------
// lpr_session_classifier_top
// LPR flow classifier: input register, session engine, verdict register, APB.
// ----------------------------------------------------------------------------
module lpr_session_classifier_top
  import lprsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  lprsc_item_if.sink         item_i,
  lprsc_result_if.source     result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [7:0]  thr_q;
  logic        reg_sel;

  logic        s1_valid_q, s1_valid_d;
  lprsc_item_t s1_q;
  logic        advance, in_xfer;

  logic        res_valid;
  verdict_e    res_verdict;
  logic        out_valid_q, out_valid_d;
  verdict_e    verdict_q;

  // register index sits above the byte offset
  assign reg_sel = (paddr[2] == REG_THRESHOLD);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {24'd0, thr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      thr_q <= pwdata[7:0];
    end
  end

  // a last byte may only move on when the verdict register is free or its verdict is being taken
  assign advance = s1_valid_q && (!s1_q.last_of_packet || !out_valid_q || result_o.ready);
  assign item_i.ready = !s1_valid_q || advance;
  assign in_xfer = item_i.valid && item_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) s1_valid_d = 1'b1;
    else if (advance) s1_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= '{payload_byte:    item_i.payload_byte,
                from_responder:  item_i.from_responder,
                first_of_packet: item_i.first_of_packet,
                last_of_packet:  item_i.last_of_packet,
                new_flow:        item_i.new_flow};
    end
  end

  lprsc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (s1_q),
    .threshold_i (thr_q),
    .res_valid_o (res_valid),
    .verdict_o   (res_verdict)
  );

  assign out_valid_d = res_valid || (out_valid_q && !result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) verdict_q <= res_verdict;
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.verdict = verdict_q;

endmodule

@@ src/lprsc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprsc_checker
// Port-level assertions for the LPR session classifier, bound to the top.
// ----------------------------------------------------------------------------
module lprsc_checker
  import lprsc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               item_valid,
  input logic               item_ready,
  input logic               result_valid,
  input logic               result_ready,
  input logic [1:0]         verdict,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata
);

  // pending verdict is held until its transfer
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid && !result_ready |=> result_valid)
    else $error("result valid dropped before transfer");

  a_verdict_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid && !result_ready |=> $stable(verdict))
    else $error("verdict changed while stalled");

  // input only stalls behind an untaken verdict
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_ready |-> result_valid && !result_ready)
    else $error("input stalled with output free");

  // the edge in reset clears the output stage
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !result_valid)
    else $error("result valid after reset");

  a_thr_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[2] == REG_THRESHOLD)
    |=> (paddr[2] != REG_THRESHOLD) || (prdata[7:0] == $past(pwdata[7:0])))
    else $error("threshold readback mismatch");

endmodule

bind lpr_session_classifier_top lprsc_checker u_lprsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .item_valid   (item_i.valid),
  .item_ready   (item_i.ready),
  .result_valid (result_o.valid),
  .result_ready (result_o.ready),
  .verdict      (result_o.verdict),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .prdata       (prdata)
);
